// ===== src/rmdr_pkg.sv =====
// ----------------------------------------------------------------------------
// rmdr_pkg
// Shared types and constants for the recent message dedup ring.
// ----------------------------------------------------------------------------
package rmdr_pkg;

    localparam int SEQ_W   = 16;
    localparam int NODE_W  = 64;
    localparam int STAMP_W = 32;
    localparam int WIN_W   = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd60;

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_HOLD  = 3'b100
    } state_t;

endpackage

// ===== src/rmdr_cell.sv =====
// ----------------------------------------------------------------------------
// rmdr_cell
// One ring entry. Shifts its entry to the next cell on a mark and folds its
// own match against the broadcast query into the hit chain every cycle.
// ----------------------------------------------------------------------------
module rmdr_cell #(
    parameter int ID_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic                         valid_in,
    input  logic [rmdr_pkg::SEQ_W-1:0]   seq_in,
    input  logic [ID_BITS-1:0]           node_in,
    input  logic [rmdr_pkg::STAMP_W-1:0] stamp_in,
    output logic                         valid_out,
    output logic [rmdr_pkg::SEQ_W-1:0]   seq_out,
    output logic [ID_BITS-1:0]           node_out,
    output logic [rmdr_pkg::STAMP_W-1:0] stamp_out,
    input  logic [rmdr_pkg::SEQ_W-1:0]   q_seq,
    input  logic [ID_BITS-1:0]           q_node,
    input  logic [rmdr_pkg::STAMP_W-1:0] q_now,
    input  logic [rmdr_pkg::WIN_W-1:0]   q_window,
    input  logic                         hit_in,
    output logic                         hit_out
);

    logic                         valid_reg;
    logic [rmdr_pkg::SEQ_W-1:0]   seq_reg;
    logic [ID_BITS-1:0]           node_reg;
    logic [rmdr_pkg::STAMP_W-1:0] stamp_reg;
    logic                         hit_reg;
    logic                         hit_next;
    logic [rmdr_pkg::STAMP_W-1:0] age;
    logic                         match;

    assign age   = q_now - stamp_reg;
    assign match = valid_reg && (seq_reg == q_seq) && (node_reg == q_node) &&
                   (age < {{(rmdr_pkg::STAMP_W - rmdr_pkg::WIN_W){1'b0}}, q_window});
    assign hit_next = hit_in | match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            if (shift_en)
            begin
                valid_reg <= valid_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            seq_reg   <= seq_in;
            node_reg  <= node_in;
            stamp_reg <= stamp_in;
        end
    end

    assign valid_out = valid_reg;
    assign seq_out   = seq_reg;
    assign node_out  = node_reg;
    assign stamp_out = stamp_reg;
    assign hit_out   = hit_reg;

endmodule

// ===== src/recent_message_dedup_ring_top.sv =====
// ----------------------------------------------------------------------------
// recent_message_dedup_ring_top
// Duplicate message filter built as a shift chain of ring entry cells.
//
// Input channel (in_valid/in_ready) carries command, sequence_req, node_id.
// Output channel (out_valid/out_ready) carries seen; every input transfer
// produces exactly one output transfer, in order.
// cfg_wr_en/cfg_wr_data write window_seconds (reset 60).
// Mark: the new entry enters cell 0 and every entry moves one cell on; the
// entry leaving the last cell is the oldest one. Tick: seconds counter + 1.
// Mark, tick and the unused code can follow back to back while the output
// register is free; the result is registered.
// Check: the query is broadcast to all cells and a registered hit chain
// ripples through the RING_ENTRIES cells; no new item is taken while the
// sweep runs, so one check finishes before the next item is taken.
// Reset clears all entry valid bits and the seconds counter; window is 60.
// If the receiver stalls, one finished result waits in the output register
// and the next item is still taken; its result is parked and input then
// stalls until the output register drains.
// ----------------------------------------------------------------------------
module recent_message_dedup_ring_top #(
    parameter int RING_ENTRIES = 64,
    parameter int ID_BYTES     = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic [rmdr_pkg::SEQ_W-1:0]   sequence_req,
    input  logic [rmdr_pkg::NODE_W-1:0]  node_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         seen,
    input  logic                         cfg_wr_en,
    input  logic [rmdr_pkg::WIN_W-1:0]   cfg_wr_data
);

    localparam int ID_BITS = 8 * ID_BYTES;
    localparam int CNT_W   = $clog2(RING_ENTRIES + 1);

    rmdr_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [rmdr_pkg::SEQ_W-1:0]   q_seq_reg, q_seq_next;
    logic [ID_BITS-1:0]           q_node_reg, q_node_next;
    logic [rmdr_pkg::STAMP_W-1:0] now_reg, now_next;
    logic [rmdr_pkg::WIN_W-1:0]   window_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         seen_reg, seen_next;
    logic                         pend_reg, pend_next;
    logic                         accept;
    logic                         out_free;
    logic                         shift_en;
    logic [ID_BITS-1:0]           node_masked;

    logic [RING_ENTRIES-1:0]      chain_valid;
    logic [rmdr_pkg::SEQ_W-1:0]   chain_seq   [RING_ENTRIES];
    logic [ID_BITS-1:0]           chain_node  [RING_ENTRIES];
    logic [rmdr_pkg::STAMP_W-1:0] chain_stamp [RING_ENTRIES];
    logic [RING_ENTRIES-1:0]      chain_hit;

    assign node_masked = node_id[ID_BITS-1:0];
    assign in_ready    = (state_reg == rmdr_pkg::ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;

    for (genvar i = 0; i < RING_ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            rmdr_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .valid_in  (1'b1),
                .seq_in    (sequence_req),
                .node_in   (node_masked),
                .stamp_in  (now_reg),
                .valid_out (chain_valid[i]),
                .seq_out   (chain_seq[i]),
                .node_out  (chain_node[i]),
                .stamp_out (chain_stamp[i]),
                .q_seq     (q_seq_reg),
                .q_node    (q_node_reg),
                .q_now     (now_reg),
                .q_window  (window_reg),
                .hit_in    (1'b0),
                .hit_out   (chain_hit[i])
            );
        end
        else
        begin : g_body
            rmdr_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .valid_in  (chain_valid[i-1]),
                .seq_in    (chain_seq[i-1]),
                .node_in   (chain_node[i-1]),
                .stamp_in  (chain_stamp[i-1]),
                .valid_out (chain_valid[i]),
                .seq_out   (chain_seq[i]),
                .node_out  (chain_node[i]),
                .stamp_out (chain_stamp[i]),
                .q_seq     (q_seq_reg),
                .q_node    (q_node_reg),
                .q_now     (now_reg),
                .q_window  (window_reg),
                .hit_in    (chain_hit[i-1]),
                .hit_out   (chain_hit[i])
            );
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        q_seq_next     = q_seq_reg;
        q_node_next    = q_node_reg;
        now_next       = now_reg;
        pend_next      = pend_reg;
        shift_en       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        seen_next      = seen_reg;

        case (state_reg)
            rmdr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        rmdr_pkg::CMD_CHECK:
                        begin
                            q_seq_next  = sequence_req;
                            q_node_next = node_masked;
                            cnt_next    = '0;
                            state_next  = rmdr_pkg::ST_SWEEP;
                        end
                        rmdr_pkg::CMD_MARK:
                        begin
                            shift_en = 1'b1;
                        end
                        rmdr_pkg::CMD_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        default:
                        begin
                            now_next = now_reg;
                        end
                    endcase
                    if (command != rmdr_pkg::CMD_CHECK)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            seen_next      = 1'b0;
                        end
                        else
                        begin
                            pend_next  = 1'b0;
                            state_next = rmdr_pkg::ST_HOLD;
                        end
                    end
                end
            end
            rmdr_pkg::ST_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RING_ENTRIES))
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        seen_next      = chain_hit[RING_ENTRIES-1];
                        state_next     = rmdr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pend_next  = chain_hit[RING_ENTRIES-1];
                        state_next = rmdr_pkg::ST_HOLD;
                    end
                end
            end
            rmdr_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    seen_next      = pend_reg;
                    state_next     = rmdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmdr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmdr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            now_reg       <= '0;
            window_reg    <= rmdr_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_seq_reg  <= q_seq_next;
        q_node_reg <= q_node_next;
        pend_reg   <= pend_next;
        seen_reg   <= seen_next;
    end

    assign out_valid = out_valid_reg;
    assign seen      = seen_reg;

    // no new transfer while the hit chain is settling
    a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rmdr_pkg::ST_SWEEP |-> !in_ready)
        else $error("input taken during sweep");

    a_sweep_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rmdr_pkg::ST_SWEEP |-> cnt_reg <= CNT_W'(RING_ENTRIES))
        else $error("sweep counter overran");

    a_hold_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rmdr_pkg::ST_HOLD |-> out_valid_reg)
        else $error("parked result with empty output register");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == rmdr_pkg::CMD_TICK |=> now_reg == $past(now_reg) + 1'b1)
        else $error("tick did not advance seconds");

    a_mark_fills_head: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == rmdr_pkg::CMD_MARK |=> chain_valid[0])
        else $error("mark did not fill head cell");

endmodule
